@@ hdl/cpr_pkg.sv @@
// Package for the complex phase rotator: payload structs, register codes
// and fixed widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cpr_pkg;
  localparam int SampleW = 16;
  localparam int PhasorW = 18;
  localparam int FracW = PhasorW - 2;

  typedef struct packed {
    logic signed [SampleW-1:0] in_re;
    logic signed [SampleW-1:0] in_im;
    logic                      first;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] out_re;
    logic signed [SampleW-1:0] out_im;
  } out_item_t;

  typedef enum logic [1:0] {
    REG_INC_RE   = 2'd0,
    REG_INC_IM   = 2'd1,
    REG_START_RE = 2'd2,
    REG_START_IM = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ADV, ST_SQRT, ST_DIV_RE, ST_DIV_IM, ST_SEND
  } back_state_t;
endpackage
`default_nettype wire

@@ hdl/cpr_front.sv @@
// Front part of the complex phase rotator: a two-entry queue that takes input
// beats and hands them to the back part. Depends on cpr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpr_front (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  output logic               in_ready,
  input  wire cpr_pkg::in_item_t in_data,
  output logic               q_valid,
  input  wire                logic q_ready,
  output cpr_pkg::in_item_t  q_data
);
  import cpr_pkg::*;
  in_item_t   mem_r [2];
  logic       wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_data;
    end
  end
endmodule
`default_nettype wire

@@ hdl/cpr_back.sv @@
// Back part of the complex phase rotator: sample rotation, phasor advance and
// periodic renormalization with a bit-serial square root and divider.
// Depends on cpr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpr_back #(
  parameter int RenormPeriod = 512
) (
  input  wire                 logic clk,
  input  wire                 logic rst_n,
  input  wire                 logic q_valid,
  output logic                q_ready,
  input  wire cpr_pkg::in_item_t q_data,
  input  wire                 logic signed [cpr_pkg::PhasorW-1:0] inc_re,
  input  wire                 logic signed [cpr_pkg::PhasorW-1:0] inc_im,
  input  wire                 logic signed [cpr_pkg::PhasorW-1:0] start_re,
  input  wire                 logic signed [cpr_pkg::PhasorW-1:0] start_im,
  output logic                out_valid,
  input  wire                 logic out_ready,
  output cpr_pkg::out_item_t  out_data
);
  import cpr_pkg::*;
  localparam int CntW = $clog2(RenormPeriod + 1);
  localparam int PW = PhasorW;
  localparam int ProdW = SampleW + PW + 1;
  localparam int SumW = PW + PW + 2;
  localparam int SqW = 2 * PW;
  localparam int DivW = PW + FracW;

  back_state_t st_r, st_nxt;
  logic signed [PW-1:0] ph_re_r, ph_im_r;
  logic [CntW-1:0] cnt_r;
  logic signed [ProdW-1:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [SumW-1:0] qa_r, qb_r, qc_r, qd_r;
  logic [1:0] phase_r;
  out_item_t y_r;
  out_item_t res_r;
  logic out_valid_r;
  // Square root and divider state.
  logic [SqW-1:0] sq_n_r, sq_res_r, sq_bit_r;
  logic [PW-1:0] mag_r;
  logic [DivW-1:0] dv_q_r;
  logic [PW:0] dv_rem_r;
  logic [$clog2(DivW+1)-1:0] dv_i_r;

  logic signed [PW-1:0] cur_re, cur_im;
  logic accept;

  assign cur_re  = q_data.first ? start_re : ph_re_r;
  assign cur_im  = q_data.first ? start_im : ph_im_r;
  assign q_ready = (st_r == ST_IDLE);
  assign accept  = q_valid && q_ready;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  function automatic logic signed [SampleW-1:0] sat_s(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] t;
    t = v >>> FracW;
    if (t > SumW'(2**(SampleW-1) - 1)) return {1'b0, {(SampleW-1){1'b1}}};
    if (t < -SumW'(2**(SampleW-1))) return {1'b1, {(SampleW-1){1'b0}}};
    return t[SampleW-1:0];
  endfunction

  function automatic logic signed [PW-1:0] sat_p(input logic signed [SumW+1:0] v);
    if (v > (SumW+2)'(2**(PW-1) - 1)) return {1'b0, {(PW-1){1'b1}}};
    if (v < -(SumW+2)'(2**(PW-1))) return {1'b1, {(PW-1){1'b0}}};
    return v[PW-1:0];
  endfunction

  logic [PW-1:0] abs_re, abs_im, dv_src;
  logic [DivW-1:0] dv_num;
  logic [PW+1:0] dv_trial;
  logic [PW:0] dv_shift;
  logic [SqW-1:0] sq_try;
  logic signed [PW+2:0] sgn_q;
  assign abs_re = ph_re_r[PW-1] ? PW'(-ph_re_r) : ph_re_r;
  assign abs_im = ph_im_r[PW-1] ? PW'(-ph_im_r) : ph_im_r;
  assign dv_src = (st_r == ST_DIV_RE) ? abs_re : abs_im;
  assign dv_num = {dv_src, {FracW{1'b0}}} + DivW'(mag_r >> 1);
  assign dv_shift = {dv_rem_r[PW-1:0], dv_num[dv_i_r - 1'b1]};
  assign dv_trial = {1'b0, dv_shift} - {2'b0, mag_r};
  assign sq_try = sq_res_r + sq_bit_r;
  assign sgn_q = (st_r == ST_DIV_RE ? ph_re_r[PW-1] : ph_im_r[PW-1])
                 ? -(PW+3)'(dv_q_r) : (PW+3)'(dv_q_r);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:   if (accept) st_nxt = ST_MUL;
      ST_MUL:    st_nxt = ST_ADV;
      ST_ADV:    if (phase_r == 2'd1) begin
        st_nxt = (cnt_r + 1'b1 >= CntW'(RenormPeriod)) ? ST_SQRT : ST_SEND;
      end
      ST_SQRT:   if (sq_bit_r == '0) st_nxt = (sq_res_r == '0) ? ST_SEND : ST_DIV_RE;
      ST_DIV_RE: if (dv_i_r == '0) st_nxt = ST_DIV_IM;
      ST_DIV_IM: if (dv_i_r == '0) st_nxt = ST_SEND;
      ST_SEND:   if (!out_valid_r || out_ready) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ph_re_r <= PW'(1) <<< FracW;
      ph_im_r <= '0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
      phase_r <= '0;
    end else begin
      if (st_r == ST_SEND && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
        res_r <= y_r;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        ST_IDLE: if (accept) begin
          ph_re_r <= cur_re;
          ph_im_r <= cur_im;
          if (q_data.first) cnt_r <= '0;
          pa_r <= ProdW'(q_data.in_re * cur_re);
          pb_r <= ProdW'(q_data.in_im * cur_im);
          pc_r <= ProdW'(q_data.in_re * cur_im);
          pd_r <= ProdW'(q_data.in_im * cur_re);
          phase_r <= 2'd0;
        end
        ST_MUL: begin
          y_r.out_re <= sat_s(SumW'(pa_r) - SumW'(pb_r) + SumW'(2**(FracW-1)));
          y_r.out_im <= sat_s(SumW'(pc_r) + SumW'(pd_r) + SumW'(2**(FracW-1)));
          qa_r <= SumW'(inc_re * ph_re_r);
          qb_r <= SumW'(inc_im * ph_im_r);
          qc_r <= SumW'(inc_re * ph_im_r);
          qd_r <= SumW'(inc_im * ph_re_r);
        end
        ST_ADV: begin
          phase_r <= 2'd1;
          if (phase_r == 2'd0) begin
            ph_re_r <= sat_p(((SumW+2)'(qa_r) - (SumW+2)'(qb_r)
                              + (SumW+2)'(2**(FracW-1))) >>> FracW);
            ph_im_r <= sat_p(((SumW+2)'(qc_r) + (SumW+2)'(qd_r)
                              + (SumW+2)'(2**(FracW-1))) >>> FracW);
          end else if (cnt_r + 1'b1 >= CntW'(RenormPeriod)) begin
            cnt_r <= '0;
            sq_n_r <= abs_re * abs_re + abs_im * abs_im;
            sq_res_r <= '0;
            sq_bit_r <= SqW'(1) << (SqW - 2);
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_SQRT: begin
          if (sq_bit_r != '0) begin
            if (sq_n_r >= sq_try) begin
              sq_n_r <= sq_n_r - sq_try;
              sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
            end else begin
              sq_res_r <= sq_res_r >> 1;
            end
            sq_bit_r <= sq_bit_r >> 2;
          end else begin
            mag_r <= sq_res_r[PW-1:0];
            dv_rem_r <= '0;
            dv_i_r <= ($clog2(DivW+1))'(DivW);
            dv_q_r <= '0;
          end
        end
        ST_DIV_RE, ST_DIV_IM: begin
          if (dv_i_r != '0) begin
            if (!dv_trial[PW+1]) begin
              dv_rem_r <= dv_trial[PW:0];
              dv_q_r <= {dv_q_r[DivW-2:0], 1'b1};
            end else begin
              dv_rem_r <= dv_shift;
              dv_q_r <= {dv_q_r[DivW-2:0], 1'b0};
            end
            dv_i_r <= dv_i_r - 1'b1;
          end else begin
            if (st_r == ST_DIV_RE) ph_re_r <= sat_p((SumW+2)'(sgn_q));
            else ph_im_r <= sat_p((SumW+2)'(sgn_q));
            dv_rem_r <= '0;
            dv_i_r <= ($clog2(DivW+1))'(DivW);
            dv_q_r <= '0;
          end
        end
        default: ;
      endcase
      st_r <= st_nxt;
    end
  end
endmodule
`default_nettype wire

@@ hdl/complex_phase_rotator.sv @@
// Top level of the complex phase rotator: APB register file, input queue
// and execution back part. Depends on cpr_pkg, cpr_front and cpr_back.
//
// Usage: samples enter on the in_ valid/ready channel, one beat per sample;
// a beat with first set reloads the start phasor. Each sample yields exactly
// one rotated beat on the out_ channel. The cfg_ port is an APB slave with
// four 18-bit signed registers in 32-bit words: inc_re, inc_im, start_re,
// start_im.
// A sample passes the queue register, then the back part's accept, multiply,
// two advance steps and hand-off to the output register. The back part takes
// no new sample until it has handed the last one off. Every RenormPeriod-th
// sample also runs the bit-serial square root and the two divisions; a zero
// phasor skips the divisions. A two-beat queue lets input keep arriving
// meanwhile. A stalled receiver holds the output register and then the back
// part; the queue fills and in_ready falls. Reset empties the queue, restores
// the unit phasor and the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module complex_phase_rotator #(
  parameter int RenormPeriod = 512
) (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  output logic               in_ready,
  input  wire cpr_pkg::in_item_t in_data,
  output logic               out_valid,
  input  wire                logic out_ready,
  output cpr_pkg::out_item_t out_data,
  input  wire                logic cfg_psel,
  input  wire                logic cfg_penable,
  input  wire                logic cfg_pwrite,
  input  wire                logic [3:0] cfg_paddr,
  input  wire                logic [31:0] cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import cpr_pkg::*;
  logic signed [PhasorW-1:0] inc_re_r, inc_im_r, start_re_r, start_im_r;
  logic q_valid, q_ready;
  in_item_t q_data;
  reg_idx_t idx;
  logic wr;

  assign cfg_pready = 1'b1;
  assign idx = reg_idx_t'(cfg_paddr[3:2]);
  assign wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00;

  always_comb begin
    unique case (idx)
      REG_INC_RE:   cfg_prdata = 32'(inc_re_r);
      REG_INC_IM:   cfg_prdata = 32'(inc_im_r);
      REG_START_RE: cfg_prdata = 32'(start_re_r);
      REG_START_IM: cfg_prdata = 32'(start_im_r);
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_re_r <= PhasorW'(1) <<< FracW;
      inc_im_r <= '0;
      start_re_r <= PhasorW'(1) <<< FracW;
      start_im_r <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_INC_RE:   inc_re_r <= cfg_pwdata[PhasorW-1:0];
        REG_INC_IM:   inc_im_r <= cfg_pwdata[PhasorW-1:0];
        REG_START_RE: start_re_r <= cfg_pwdata[PhasorW-1:0];
        REG_START_IM: start_im_r <= cfg_pwdata[PhasorW-1:0];
        default: ;
      endcase
    end
  end

  cpr_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_valid, .q_ready, .q_data
  );

  cpr_back #(.RenormPeriod(RenormPeriod)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data,
    .inc_re(inc_re_r), .inc_im(inc_im_r),
    .start_re(start_re_r), .start_im(start_im_r),
    .out_valid, .out_ready, .out_data
  );
endmodule
`default_nettype wire

@@ hdl/cpr_checker.sv @@
// Port-level checks for the complex phase rotator, bound to the top level.
// Depends on cpr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpr_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire cpr_pkg::out_item_t out_data,
  input wire logic cfg_pready
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out hold");
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid) else $error("in hold");
  a_pready: assert property (@(posedge clk) cfg_pready) else $error("pready low");
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid) else $error("out after reset");
  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_ready) else $error("in after reset");
endmodule

bind complex_phase_rotator cpr_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data, .cfg_pready
);
`default_nettype wire
